>>> hw/rtl/bounds_metadata_shadow_stack_top_defines.svh
// Assertion macros shared by the shadow stack checker.
`ifndef BOUNDS_METADATA_SHADOW_STACK_TOP_DEFINES_SVH
`define BOUNDS_METADATA_SHADOW_STACK_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BMSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BMSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/bmss_pkg.sv
// Shared constants for the pointer bounds shadow stack.
`timescale 1ns / 1ps
package bmss_pkg;

  localparam int STACK_WORDS_DEF = 4096;
  localparam int WORD_W          = 64;
  localparam int FUNC_W          = 3;
  localparam int ARG_W           = 11;
  localparam int STATUS_W        = 2;
  localparam int TOP_W           = 12;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH        = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP         = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_STORE_BOTH  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_BOTH   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_STORE_BASE  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_STORE_BOUND = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BEYOND    = 2'd3;

endpackage

>>> hw/rtl/bounds_metadata_shadow_stack_top.sv
// Pointer bounds shadow stack: frame sequencer around one single-port word memory.
`timescale 1ns / 1ps
// Frames of pointer bounds live in one STACK_WORDS x 64 single-port memory with
// a registered read. After reset the block sweeps the memory to zero, one word a
// cycle, over every address, and holds in_ready low until the sweep ends.
// Items are handled one at a time because every access goes through the one
// memory port: pop, store base, store bound and the unused codes finish in the
// execute state, as do failed items; push, store both and load both go on to a
// second state (push reads the current header, then writes the two new header
// words; the paired operations make two accesses). A finished result waits in
// the output register, and a new item is accepted while it waits; if the result
// register is still full when the next item finishes, that item is parked and
// the block takes no new item until it leaves. Failed operations (overflow,
// underflow, slot beyond the store) leave the memory and the top pointer unchanged.
module bounds_metadata_shadow_stack_top #(
  parameter int STACK_WORDS = bmss_pkg::STACK_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bmss_pkg::FUNC_W-1:0]   in_func,
  input  logic [bmss_pkg::ARG_W-1:0]    in_arg_count,
  input  logic [bmss_pkg::ARG_W-1:0]    in_arg_index,
  input  logic [bmss_pkg::WORD_W-1:0]   in_base_value,
  input  logic [bmss_pkg::WORD_W-1:0]   in_bound_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bmss_pkg::WORD_W-1:0]   out_base_out,
  output logic [bmss_pkg::WORD_W-1:0]   out_bound_out,
  output logic [bmss_pkg::STATUS_W-1:0] out_status,
  output logic [bmss_pkg::TOP_W-1:0]    out_top_position
);

  localparam int AW  = $clog2(STACK_WORDS);
  localparam int PW  = (AW > bmss_pkg::TOP_W) ? AW : bmss_pkg::TOP_W;
  // Position arithmetic width: top plus a header plus a full frame
  localparam int NW  = PW + 3;
  localparam int WW  = bmss_pkg::WORD_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WR2  = 3'd2;
  localparam logic [2:0] S_LD2  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [NW-1:0] SW_N = NW'(STACK_WORDS);
  localparam logic [WW-1:0] SW_W = WW'(STACK_WORDS);

  // Word memory
  logic [WW-1:0] mem [STACK_WORDS];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [WW-1:0] mem_wdata;
  logic [WW-1:0] rdata_r;

  // Control state
  logic [2:0]    state_r, state_nxt;
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] top_r, top_nxt;

  // Captured item
  logic [bmss_pkg::FUNC_W-1:0] func_r;
  logic [bmss_pkg::ARG_W-1:0]  count_r;
  logic [WW-1:0]               base_r, bound_r;
  logic [AW-1:0]               base_pos_r, bound_pos_r;
  logic                        beyond_r, prev_ok_r;

  // Second access and load holding
  logic [AW-1:0] wr2_addr_r, wr2_addr_nxt;
  logic [WW-1:0] wr2_data_r, wr2_data_nxt;
  logic [WW-1:0] rbase_r;

  // Result holding and output register
  logic [WW-1:0]                 res_base_r, res_bound_r;
  logic [bmss_pkg::STATUS_W-1:0] res_status_r;
  logic [AW-1:0]                 res_top_r;
  logic                          out_valid_r;
  logic [WW-1:0]                 out_base_r, out_bound_r;
  logic [bmss_pkg::STATUS_W-1:0] out_status_r;
  logic [bmss_pkg::TOP_W-1:0]    out_top_r;

  logic                          accept;
  logic                          out_free;
  logic                          fin;
  logic [WW-1:0]                 fin_base, fin_bound;
  logic [bmss_pkg::STATUS_W-1:0] fin_status;
  logic [AW-1:0]                 fin_top;
  logic [PW-1:0]                 fin_top_ext, done_top_ext;

  // Positions derived from the incoming item
  logic [NW-1:0] in_base_pos, in_bound_pos, in_hdr_pos;
  logic          in_beyond;

  // Push and pop arithmetic on the header read
  logic [WW-1:0] prev;
  logic          push_ovf;
  logic [NW-1:0] ntop_n;
  logic [WW-1:0] top_w;
  logic          pop_unf;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !clr_busy_r;
  assign out_free = !out_valid_r || out_ready;

  assign in_base_pos  = NW'(top_r) + NW'(2) + (NW'(in_arg_index) << 1);
  assign in_bound_pos = in_base_pos + NW'(1);
  assign in_hdr_pos   = NW'(top_r) + NW'(1);

  // Flag a slot at or past the end of the store
  always_comb begin
    case (in_func)
      bmss_pkg::FUNC_STORE_BOTH,
      bmss_pkg::FUNC_LOAD_BOTH,
      bmss_pkg::FUNC_STORE_BOUND: in_beyond = (in_bound_pos >= SW_N);
      bmss_pkg::FUNC_STORE_BASE:  in_beyond = (in_base_pos >= SW_N);
      default:                    in_beyond = 1'b0;
    endcase
  end

  // Header checks for push and pop
  assign prev     = prev_ok_r ? rdata_r : '0;
  assign ntop_n   = NW'(top_r) + NW'(prev[PW:0]) + NW'(2);
  assign push_ovf = (prev > SW_W) ||
                    ((ntop_n + NW'(2) + (NW'(count_r) << 1)) > SW_N);
  assign top_w    = WW'(top_r);
  assign pop_unf  = (top_w < WW'(2)) || (rdata_r > (top_w - WW'(2)));

  // Sequence the item and drive the memory port
  always_comb begin
    state_nxt    = state_r;
    top_nxt      = top_r;
    wr2_addr_nxt = wr2_addr_r;
    wr2_data_nxt = wr2_data_r;
    mem_we       = 1'b0;
    mem_addr     = top_r;
    mem_wdata    = '0;
    fin          = 1'b0;
    fin_base     = '0;
    fin_bound    = '0;
    fin_status   = bmss_pkg::ST_OK;
    fin_top      = top_r;
    case (state_r)
      S_IDLE: begin
        if (clr_busy_r) begin
          mem_we   = 1'b1;
          mem_addr = clr_addr_r;
        end else if (accept) begin
          state_nxt = S_EXEC;
          case (in_func)
            bmss_pkg::FUNC_PUSH:      mem_addr = AW'(in_hdr_pos);
            bmss_pkg::FUNC_LOAD_BOTH: mem_addr = AW'(in_base_pos);
            default:                  mem_addr = top_r;
          endcase
        end
      end
      S_EXEC: begin
        case (func_r)
          bmss_pkg::FUNC_PUSH: begin
            if (push_ovf) begin
              fin        = 1'b1;
              fin_status = bmss_pkg::ST_OVERFLOW;
            end else begin
              mem_we       = 1'b1;
              mem_addr     = AW'(ntop_n);
              mem_wdata    = prev;
              wr2_addr_nxt = AW'(ntop_n + NW'(1));
              wr2_data_nxt = WW'(count_r) << 1;
              top_nxt      = AW'(ntop_n);
              state_nxt    = S_WR2;
            end
          end
          bmss_pkg::FUNC_POP: begin
            fin = 1'b1;
            if (pop_unf) begin
              fin_status = bmss_pkg::ST_UNDERFLOW;
            end else begin
              top_nxt = AW'(top_w - rdata_r - WW'(2));
              fin_top = AW'(top_w - rdata_r - WW'(2));
            end
          end
          bmss_pkg::FUNC_STORE_BOTH: begin
            if (beyond_r) begin
              fin        = 1'b1;
              fin_status = bmss_pkg::ST_BEYOND;
            end else begin
              mem_we       = 1'b1;
              mem_addr     = base_pos_r;
              mem_wdata    = base_r;
              wr2_addr_nxt = bound_pos_r;
              wr2_data_nxt = bound_r;
              state_nxt    = S_WR2;
            end
          end
          bmss_pkg::FUNC_LOAD_BOTH: begin
            if (beyond_r) begin
              fin        = 1'b1;
              fin_status = bmss_pkg::ST_BEYOND;
            end else begin
              mem_addr  = bound_pos_r;
              state_nxt = S_LD2;
            end
          end
          bmss_pkg::FUNC_STORE_BASE: begin
            fin = 1'b1;
            if (beyond_r) begin
              fin_status = bmss_pkg::ST_BEYOND;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = base_pos_r;
              mem_wdata = base_r;
            end
          end
          bmss_pkg::FUNC_STORE_BOUND: begin
            fin = 1'b1;
            if (beyond_r) begin
              fin_status = bmss_pkg::ST_BEYOND;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = bound_pos_r;
              mem_wdata = bound_r;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_WR2: begin
        mem_we    = 1'b1;
        mem_addr  = wr2_addr_r;
        mem_wdata = wr2_data_r;
        fin       = 1'b1;
      end
      S_LD2: begin
        fin       = 1'b1;
        fin_base  = rbase_r;
        fin_bound = rdata_r;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // Hand the result over, or park it until the output register drains
    if (fin) begin
      state_nxt = out_free ? S_IDLE : S_DONE;
    end
  end

  assign fin_top_ext  = PW'(fin_top);
  assign done_top_ext = PW'(res_top_r);

  // Memory: one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      // Advance the clearing sweep
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(STACK_WORDS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if ((fin || state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wr2_addr_r <= wr2_addr_nxt;
    wr2_data_r <= wr2_data_nxt;
    if (accept) begin
      func_r      <= in_func;
      count_r     <= in_arg_count;
      base_r      <= in_base_value;
      bound_r     <= in_bound_value;
      base_pos_r  <= AW'(in_base_pos);
      bound_pos_r <= AW'(in_bound_pos);
      beyond_r    <= in_beyond;
      prev_ok_r   <= (in_hdr_pos < SW_N);
    end
    if (state_r == S_EXEC) begin
      rbase_r <= rdata_r;
    end
    // Park a result that cannot leave yet
    if (fin) begin
      res_base_r   <= fin_base;
      res_bound_r  <= fin_bound;
      res_status_r <= fin_status;
      res_top_r    <= fin_top;
    end
    // Load the output register
    if (fin && out_free) begin
      out_base_r   <= fin_base;
      out_bound_r  <= fin_bound;
      out_status_r <= fin_status;
      out_top_r    <= fin_top_ext[bmss_pkg::TOP_W-1:0];
    end else if (state_r == S_DONE && out_free) begin
      out_base_r   <= res_base_r;
      out_bound_r  <= res_bound_r;
      out_status_r <= res_status_r;
      out_top_r    <= done_top_ext[bmss_pkg::TOP_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_base_out     = out_base_r;
  assign out_bound_out    = out_bound_r;
  assign out_status       = out_status_r;
  assign out_top_position = out_top_r;

endmodule

>>> hw/rtl/bmss_checker.sv
// Port-level checks for the shadow stack, bound to the top level.
`timescale 1ns / 1ps
`include "bounds_metadata_shadow_stack_top_defines.svh"
module bmss_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [bmss_pkg::FUNC_W-1:0]   in_func,
  input logic [bmss_pkg::ARG_W-1:0]    in_arg_count,
  input logic [bmss_pkg::ARG_W-1:0]    in_arg_index,
  input logic [bmss_pkg::WORD_W-1:0]   in_base_value,
  input logic [bmss_pkg::WORD_W-1:0]   in_bound_value,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bmss_pkg::WORD_W-1:0]   out_base_out,
  input logic [bmss_pkg::WORD_W-1:0]   out_bound_out,
  input logic [bmss_pkg::STATUS_W-1:0] out_status,
  input logic [bmss_pkg::TOP_W-1:0]    out_top_position
);

  // A waiting input item holds its value
  `BMSS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_func) && $stable(in_arg_count) && $stable(in_arg_index) && $stable(in_base_value) && $stable(in_bound_value), "input item changed while waiting")

  // A stalled result holds its value
  `BMSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_base_out) && $stable(out_bound_out) && $stable(out_status) && $stable(out_top_position), "result changed while stalled")

  // Failed operations return no bounds
  `BMSS_ASSERT_NOW(a_fail_zero, out_valid && (out_status != bmss_pkg::ST_OK), (out_base_out == '0) && (out_bound_out == '0), "failed item returned bounds")

  // One item in flight: no acceptance in the cycle after one
  `BMSS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "item accepted while another is at work")

endmodule

bind bounds_metadata_shadow_stack_top bmss_checker u_bmss_checker (.*);

>>> bench/bounds_metadata_shadow_stack_checker.sv
// Checker for the shadow stack: predicts each result and compares it with the block's output.
`timescale 1ns / 1ps
module bounds_metadata_shadow_stack_checker
  import bmss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [ARG_W-1:0]    in_arg_count,
  input  logic [ARG_W-1:0]    in_arg_index,
  input  logic [WORD_W-1:0]   in_base_value,
  input  logic [WORD_W-1:0]   in_bound_value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [WORD_W-1:0]   out_base_out,
  input  logic [WORD_W-1:0]   out_bound_out,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [TOP_W-1:0]    out_top_position,
  output int                  fail_count,
  output int                  pending
);

  localparam longint unsigned DEPTH = STACK_WORDS_DEF;

  typedef struct {
    logic [FUNC_W-1:0]   func;
    logic [WORD_W-1:0]   base;
    logic [WORD_W-1:0]   bound;
    logic [STATUS_W-1:0] status;
    logic [TOP_W-1:0]    top;
  } stack_result_t;

  // Shadow copy of the word memory and the frame pointer
  logic [WORD_W-1:0] shadow_words [STACK_WORDS_DEF];
  longint unsigned   shadow_top;
  stack_result_t     results_due [$];
  int                result_num;

  // Apply one operation to the shadow stack and return the result it gives
  task automatic apply_stack_op(input logic [FUNC_W-1:0] op, input logic [ARG_W-1:0] cnt,
                                input logic [ARG_W-1:0] idx, input logic [WORD_W-1:0] bs,
                                input logic [WORD_W-1:0] bd, output stack_result_t res);
    longint unsigned base_pos;
    longint unsigned bound_pos;
    longint unsigned prev;
    longint unsigned new_top;
    res.func   = op;
    res.base   = '0;
    res.bound  = '0;
    res.status = ST_OK;
    base_pos   = shadow_top + 2 + 2 * longint'(idx);
    bound_pos  = base_pos + 1;
    case (op)
      FUNC_PUSH: begin
        prev = (shadow_top + 1 < DEPTH) ? shadow_words[shadow_top + 1] : 0;
        if (prev > DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          new_top = shadow_top + prev + 2;
          // New header plus its slots must fit below the end of the store
          if (new_top + 2 + 2 * longint'(cnt) > DEPTH) begin
            res.status = ST_OVERFLOW;
          end else begin
            shadow_words[new_top]     = prev;
            shadow_words[new_top + 1] = 2 * longint'(cnt);
            shadow_top                = new_top;
          end
        end
      end
      FUNC_POP: begin
        prev = shadow_words[shadow_top];
        if (prev > shadow_top || prev + 2 > shadow_top) begin
          res.status = ST_UNDERFLOW;
        end else begin
          shadow_top = shadow_top - prev - 2;
        end
      end
      FUNC_STORE_BOTH: begin
        if (bound_pos >= DEPTH) begin
          res.status = ST_BEYOND;
        end else begin
          shadow_words[base_pos]  = bs;
          shadow_words[bound_pos] = bd;
        end
      end
      FUNC_LOAD_BOTH: begin
        if (bound_pos >= DEPTH) begin
          res.status = ST_BEYOND;
        end else begin
          res.base  = shadow_words[base_pos];
          res.bound = shadow_words[bound_pos];
        end
      end
      FUNC_STORE_BASE: begin
        if (base_pos >= DEPTH) res.status = ST_BEYOND;
        else shadow_words[base_pos] = bs;
      end
      FUNC_STORE_BOUND: begin
        if (bound_pos >= DEPTH) res.status = ST_BEYOND;
        else shadow_words[bound_pos] = bd;
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase
    res.top = shadow_top[TOP_W-1:0];
  endtask

  // Report one field that differs from its expectation
  function automatic void check_field(string label, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: result %0d %s mismatch, expected %h actual %h",
               $time, result_num, label, want, got);
      fail_count++;
    end
  endfunction

  // Watch both channels at the rising edge
  always @(posedge clk) begin : watch_channels
    stack_result_t due;
    if (!rst_n) begin
      foreach (shadow_words[i]) shadow_words[i] = '0;
      shadow_top = 0;
      results_due.delete();
      fail_count = 0;
      result_num = 0;
    end else begin
      // Compare a delivered item with the oldest expectation
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %h top %h",
                   $time, out_status, out_top_position);
          fail_count++;
        end else begin
          due = results_due.pop_front();
          check_field("base_out", due.base, out_base_out);
          check_field("bound_out", due.bound, out_bound_out);
          check_field("status", WORD_W'(due.status), WORD_W'(out_status));
          check_field("top_position", WORD_W'(due.top), WORD_W'(out_top_position));
        end
        result_num++;
      end
      // Predict the result of an accepted item
      if (in_valid && in_ready) begin
        apply_stack_op(in_func, in_arg_count, in_arg_index, in_base_value, in_bound_value,
                       due);
        results_due.push_back(due);
      end
    end
    pending = results_due.size();
  end

endmodule

>>> bench/bounds_metadata_shadow_stack_top_tb.sv
// Testbench top for the shadow stack: drives items, paces the result side and gives the verdict.
`timescale 1ns / 1ps
module bounds_metadata_shadow_stack_top_tb;
  import bmss_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;
  localparam logic [WORD_W-1:0] ALL_ONES     = {WORD_W{1'b1}};
  localparam int RANDOM_ITEMS = 1600;
  localparam int IDLE_LIMIT   = 20000;
  localparam int LONG_HOLD    = 400;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func;
  logic [ARG_W-1:0]    in_arg_count;
  logic [ARG_W-1:0]    in_arg_index;
  logic [WORD_W-1:0]   in_base_value;
  logic [WORD_W-1:0]   in_bound_value;
  logic                out_valid;
  logic                out_ready;
  logic [WORD_W-1:0]   out_base_out;
  logic [WORD_W-1:0]   out_bound_out;
  logic [STATUS_W-1:0] out_status;
  logic [TOP_W-1:0]    out_top_position;

  int fail_count;
  int pending;
  int idle_cycles;
  bit tx_free;
  bit rx_free;
  bit rx_hold_req;

  bounds_metadata_shadow_stack_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_arg_count     (in_arg_count),
    .in_arg_index     (in_arg_index),
    .in_base_value    (in_base_value),
    .in_bound_value   (in_bound_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_base_out     (out_base_out),
    .out_bound_out    (out_bound_out),
    .out_status       (out_status),
    .out_top_position (out_top_position)
  );

  bounds_metadata_shadow_stack_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_arg_count     (in_arg_count),
    .in_arg_index     (in_arg_index),
    .in_base_value    (in_base_value),
    .in_bound_value   (in_bound_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_base_out     (out_base_out),
    .out_bound_out    (out_bound_out),
    .out_status       (out_status),
    .out_top_position (out_top_position),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Operation mix, with pushes against pops set by the caller
  function automatic logic [FUNC_W-1:0] pick_func(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return FUNC_PUSH;
    if (r < 50) return FUNC_POP;
    if (r < 64) return FUNC_STORE_BOTH;
    if (r < 80) return FUNC_LOAD_BOTH;
    if (r < 88) return FUNC_STORE_BASE;
    if (r < 96) return FUNC_STORE_BOUND;
    return (r < 98) ? FUNC_SPARE_A : FUNC_SPARE_B;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    return {$urandom(), $urandom()};
  endfunction

  // Offer one item from a falling edge and hold it until accepted
  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [ARG_W-1:0] cnt,
                         input logic [ARG_W-1:0] idx, input logic [WORD_W-1:0] bs,
                         input logic [WORD_W-1:0] bd);
    int gap;
    gap = tx_free ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= op;
    in_arg_count   <= cnt;
    in_arg_index   <= idx;
    in_base_value  <= bs;
    in_bound_value <= bd;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Result side: random stalls, free stretches and one long hold-off on request
  initial begin : drive_out_ready
    int hold_left;
    int stall_left;
    bit hold_taken;
    hold_left  = 0;
    stall_left = 0;
    hold_taken = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_free) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("bounds_metadata_shadow_stack_top_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict
  initial begin : run_items
    int                push_pct;
    int                r;
    logic [ARG_W-1:0]  cnt;
    logic [ARG_W-1:0]  idx;
    tx_free        = 1'b0;
    rx_free        = 1'b0;
    rx_hold_req    = 1'b0;
    push_pct       = 25;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_PUSH;
    in_arg_count   = '0;
    in_arg_index   = '0;
    in_base_value  = '0;
    in_bound_value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty stack, field extremes, spare codes
    send_op(FUNC_POP, '0, '0, '0, '0);
    send_op(FUNC_LOAD_BOTH, '0, '0, ALL_ONES, ALL_ONES);
    send_op(FUNC_STORE_BOTH, '0, '0, ALL_ONES, ALL_ONES);
    send_op(FUNC_LOAD_BOTH, '0, '0, '0, '0);
    send_op(FUNC_STORE_BASE, '0, 11'd1, '0, ALL_ONES);
    send_op(FUNC_STORE_BOUND, '0, 11'd1, '0, ALL_ONES);
    send_op(FUNC_LOAD_BOTH, '0, 11'd1, '0, '0);
    send_op(FUNC_SPARE_A, 11'd2047, 11'd2047, ALL_ONES, ALL_ONES);
    send_op(FUNC_SPARE_B, 11'd1024, 11'd5, 64'h8000_0000_0000_0001, 64'h1);
    // Push that overflows, then one that exactly fills the store
    send_op(FUNC_PUSH, 11'd2047, '0, '0, '0);
    send_op(FUNC_PUSH, 11'd2046, '0, '0, '0);
    // Slots at and past the end of the store
    send_op(FUNC_STORE_BOTH, '0, 11'd2046, ALL_ONES, '0);
    send_op(FUNC_STORE_BOTH, '0, 11'd2045, 64'h0123_4567_89ab_cdef, ALL_ONES);
    send_op(FUNC_STORE_BASE, '0, 11'd2046, ALL_ONES, ALL_ONES);
    send_op(FUNC_STORE_BOUND, '0, 11'd2046, ALL_ONES, ALL_ONES);
    send_op(FUNC_STORE_BOUND, '0, 11'd2045, '0, 64'hfedc_ba98_7654_3210);
    send_op(FUNC_LOAD_BOTH, '0, 11'd2045, '0, '0);
    send_op(FUNC_LOAD_BOTH, '0, 11'd2047, '0, '0);
    // Push with no room left even for an empty frame
    send_op(FUNC_PUSH, '0, '0, '0, '0);
    // Unwind to the bottom and underflow there
    send_op(FUNC_POP, '0, '0, '0, '0);
    send_op(FUNC_POP, '0, '0, '0, '0);
    // Small nested frames
    send_op(FUNC_PUSH, '0, '0, '0, '0);
    send_op(FUNC_PUSH, 11'd1, '0, '0, '0);
    send_op(FUNC_STORE_BOTH, '0, '0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_op(FUNC_POP, '0, '0, '0, '0);

    // Random: mostly small frames with in-frame slots, some huge or far-off values
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) push_pct = $urandom_range(15, 40);
      if (n == 300) rx_hold_req = 1'b1;
      if (n == 800) begin
        // Hold the sender until every result is back
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      tx_free = (n >= 1000 && n < 1200);
      rx_free = tx_free;
      r = $urandom_range(0, 99);
      if (r < 85) cnt = ARG_W'($urandom_range(0, 6));
      else if (r < 95) cnt = ARG_W'($urandom_range(7, 64));
      else cnt = ARG_W'($urandom_range(0, 2047));
      r = $urandom_range(0, 99);
      if (r < 80) idx = ARG_W'($urandom_range(0, 7));
      else if (r < 92) idx = ARG_W'($urandom_range(0, 2047));
      else idx = ARG_W'($urandom_range(2040, 2047));
      send_op(pick_func(push_pct), cnt, idx, pick_word(), pick_word());
    end
    in_valid <= 1'b0;
    tx_free = 1'b0;
    rx_free = 1'b0;

    // Drain, then let the pipeline settle
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("bounds_metadata_shadow_stack_top_tb passed");
    end else begin
      $display("bounds_metadata_shadow_stack_top_tb failed");
    end
    $finish;
  end

endmodule
